// ----- rtl/dtfs_pkg.sv -----
// Shared widths, configuration layout and constants of the throttle frame serialiser.
package dtfs_pkg;

    localparam int CODE_W      = 11;
    localparam int DUTY_W      = 16;
    localparam int PCT_W       = 8;
    localparam int PCT_SAT_W   = 7;
    localparam int FRAME_BITS  = 16;
    localparam int TRAIL_SLOTS = 2;
    localparam int TOTAL_SLOTS = FRAME_BITS + TRAIL_SLOTS;
    localparam int SLOT_W      = 5;
    localparam int NIB_W       = 4;
    localparam int WORD_W      = CODE_W + 1;

    // Register file layout of the configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DUTY_W;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_THROTTLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_OFFSET = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ONE        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ZERO       = 2'd3;

    localparam logic [CODE_W-1:0] MAX_THROTTLE_RST    = 11'd1999;
    localparam logic [CODE_W-1:0] RESERVED_OFFSET_RST = 11'd48;
    localparam logic [CODE_W-1:0] CODE_SAT            = 11'd2047;

    localparam logic [PCT_W-1:0]     PERCENT_FULL     = 8'd100;
    localparam logic [PCT_SAT_W-1:0] PERCENT_FULL_SAT = 7'd100;

    // Division by one hundred as a multiplication by a rounded-up reciprocal.
    // Exact for every dividend below 2**18, which covers 2047 * 100.
    localparam int PROD_W    = CODE_W + PCT_SAT_W;
    localparam int RECIP_W   = 19;
    localparam int DIV_SHIFT = 25;
    localparam int MUL_W     = PROD_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 19'd335545;

    // Two-entry frame queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef struct packed {
        logic [CODE_W-1:0] max_throttle;
        logic [CODE_W-1:0] reserved_offset;
        logic [DUTY_W-1:0] duty_one;
        logic [DUTY_W-1:0] duty_zero;
    } dtfs_cfg_t;

endpackage

// ----- rtl/dtfs_in_if.sv -----
// Input channel: throttle percentage and telemetry flag with a valid/ready handshake.
interface dtfs_in_if;
    import dtfs_pkg::*;

    logic             valid;
    logic             ready;
    logic [PCT_W-1:0] throttle_percent;
    logic             telemetry_request;

    modport source (output valid, output throttle_percent, output telemetry_request,
                    input ready);
    modport sink (input valid, input throttle_percent, input telemetry_request,
                  output ready);
endinterface

// ----- rtl/dtfs_out_if.sv -----
// Output channel: one timer compare value per slot with a last marker.
interface dtfs_out_if;
    import dtfs_pkg::*;

    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] duty;
    logic              last;

    modport source (output valid, output duty, output last, input ready);
    modport sink (input valid, input duty, input last, output ready);
endinterface

// ----- rtl/dtfs_front.sv -----
// Front end: scales the throttle, adds the offset and builds the checksummed frame.
module dtfs_front
    import dtfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtfs_cfg_t             cfg,
    dtfs_in_if.sink               in_ch,
    output logic                  push,
    output logic [FRAME_BITS-1:0] push_frame,
    input  logic                  queue_full
);

    logic                  s1_valid_reg, s1_valid_next;
    logic [PROD_W-1:0]     s1_prod_reg;
    logic                  s1_tel_reg;
    logic                  s2_valid_reg, s2_valid_next;
    logic [CODE_W-1:0]     s2_quot_reg;
    logic                  s2_tel_reg;

    logic                  adv1, adv2;
    logic [PCT_SAT_W-1:0]  pct_sat;
    logic [PROD_W-1:0]     prod;
    logic [MUL_W-1:0]      quot_full;
    logic [CODE_W:0]       code_sum;
    logic [CODE_W-1:0]     code;
    logic [WORD_W-1:0]     word;
    logic [NIB_W-1:0]      csum;

    assign push = s2_valid_reg && !queue_full;
    assign adv2 = !s2_valid_reg || push;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ch.ready = adv1;

    assign s1_valid_next = adv1 ? in_ch.valid : s1_valid_reg;
    assign s2_valid_next = adv2 ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        pct_sat = (in_ch.throttle_percent > PERCENT_FULL) ? PERCENT_FULL_SAT
                                                          : in_ch.throttle_percent[PCT_SAT_W-1:0];
        prod      = PROD_W'(cfg.max_throttle) * PROD_W'(pct_sat);
        quot_full = MUL_W'(s1_prod_reg) * MUL_W'(DIV_RECIP);
        code_sum  = {1'b0, s2_quot_reg} + {1'b0, cfg.reserved_offset};
        code      = code_sum[CODE_W] ? CODE_SAT : code_sum[CODE_W-1:0];
        word      = {code, s2_tel_reg};
        csum      = word[11:8] ^ word[7:4] ^ word[3:0];
        push_frame = {word, csum};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_prod_reg <= prod;
            s1_tel_reg  <= in_ch.telemetry_request;
        end
        if (adv2)
        begin
            s2_quot_reg <= quot_full[DIV_SHIFT +: CODE_W];
            s2_tel_reg  <= s1_tel_reg;
        end
    end

endmodule

// ----- rtl/dtfs_queue.sv -----
// Two-entry frame queue decoupling the front end from the slot emitter.
module dtfs_queue
    import dtfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [FRAME_BITS-1:0] push_frame,
    output logic                  full,
    input  logic                  pop,
    output logic                  not_empty,
    output logic [FRAME_BITS-1:0] head
);

    logic [FRAME_BITS-1:0] mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// ----- rtl/dtfs_back.sv -----
// Back end: shifts a frame out MSB first as compare values, then the trailing zero slots.
module dtfs_back
    import dtfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dtfs_cfg_t             cfg,
    input  logic                  frame_valid,
    input  logic [FRAME_BITS-1:0] frame,
    output logic                  pop,
    dtfs_out_if.source            out_ch
);

    logic                  busy_reg, busy_next;
    logic [FRAME_BITS-1:0] frame_shift_reg, frame_shift_next;
    logic [SLOT_W-1:0]     slot_count_reg, slot_count_next;
    logic                  out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0]     duty_reg;
    logic                  last_reg;

    logic                  load, emit, final_slot;
    logic [FRAME_BITS-1:0] src;
    logic [SLOT_W-1:0]     cnt;
    logic [DUTY_W-1:0]     slot_duty;

    assign out_ch.valid = out_valid_reg;
    assign out_ch.duty  = duty_reg;
    assign out_ch.last  = last_reg;

    // A new frame is taken straight from the queue head, so its first slot
    // follows the previous frame's last slot without a gap.
    always_comb
    begin
        load       = !out_valid_reg || out_ch.ready;
        src        = busy_reg ? frame_shift_reg : frame;
        cnt        = busy_reg ? slot_count_reg : '0;
        emit       = load && (busy_reg || frame_valid);
        pop        = load && !busy_reg && frame_valid;
        final_slot = (cnt == SLOT_W'(TOTAL_SLOTS - 1));
        if (cnt < SLOT_W'(FRAME_BITS))
        begin
            slot_duty = src[FRAME_BITS-1] ? cfg.duty_one : cfg.duty_zero;
        end
        else
        begin
            slot_duty = '0;
        end
        busy_next        = emit ? !final_slot : busy_reg;
        frame_shift_next = emit ? {src[FRAME_BITS-2:0], 1'b0} : frame_shift_reg;
        slot_count_next  = emit ? cnt + 1'b1 : slot_count_reg;
        out_valid_next   = load ? emit : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            frame_shift_reg <= '0;
            slot_count_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            frame_shift_reg <= frame_shift_next;
            slot_count_reg  <= slot_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            duty_reg <= slot_duty;
            last_reg <= final_slot;
        end
    end

endmodule

// ----- rtl/dshot_throttle_frame_serializer.sv -----
// Top level of the throttle frame serialiser: configuration registers and the three stages.
//
// Each transaction on in_ch carries a throttle percentage and a telemetry flag.
// The block turns it into a 16-bit frame (11-bit throttle code, telemetry bit,
// 4-bit checksum) and sends eighteen transactions on out_ch: sixteen timer
// compare values for the frame bits, MSB first, then two zero values, the last
// of them with last set.
// The front end is a two-stage pipeline (scale, then divide by one hundred
// through a reciprocal multiplier) that writes frames into a two-entry queue.
// The back end emits one slot per cycle from an output register while out_ch
// is ready; an input transaction passes through both front stages, the queue
// and the output register before out_ch.valid rises. Frames follow each other
// on out_ch without a gap, and in_ch keeps accepting while the queue has room.
// When out_ch is stalled the current slot is held and the queue fills; in_ch
// drops ready once the queue and both front stages are full.
// Reset clears pipeline, queue and emitter control state and restores register defaults. The
// user must write registers via cfg_we/cfg_index/cfg_data only while idle; it is unchecked.
module dshot_throttle_frame_serializer
    import dtfs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    dtfs_in_if.sink               in_ch,
    dtfs_out_if.source            out_ch
);

    dtfs_cfg_t             cfg_reg, cfg_next;
    logic                  push, queue_full, pop, queue_not_empty;
    logic [FRAME_BITS-1:0] push_frame, queue_head;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAX_THROTTLE:    cfg_next.max_throttle    = cfg_data[CODE_W-1:0];
                CFG_RESERVED_OFFSET: cfg_next.reserved_offset = cfg_data[CODE_W-1:0];
                CFG_DUTY_ONE:        cfg_next.duty_one        = cfg_data;
                CFG_DUTY_ZERO:       cfg_next.duty_zero       = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_throttle    <= MAX_THROTTLE_RST;
            cfg_reg.reserved_offset <= RESERVED_OFFSET_RST;
            cfg_reg.duty_one        <= '0;
            cfg_reg.duty_zero       <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dtfs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push       (push),
        .push_frame (push_frame),
        .queue_full (queue_full)
    );

    dtfs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .full       (queue_full),
        .pop        (pop),
        .not_empty  (queue_not_empty),
        .head       (queue_head)
    );

    dtfs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .frame_valid (queue_not_empty),
        .frame       (queue_head),
        .pop         (pop),
        .out_ch      (out_ch)
    );

endmodule

// ----- rtl/dtfs_checker.sv -----
// Port-level checker for the throttle frame serialiser, bound to the top level.
module dtfs_checker
    import dtfs_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic [DUTY_W-1:0] out_duty,
    input logic              out_last
);

    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [3:0]        pending_reg, pending_next;
    logic              in_acc, out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_comb
    begin
        slot_next    = out_acc ? (out_last ? '0 : slot_reg + 1'b1) : slot_reg;
        pending_next = pending_reg + 4'(in_acc) - 4'(out_acc && out_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            pending_reg <= '0;
        end
        else
        begin
            slot_reg    <= slot_next;
            pending_reg <= pending_next;
        end
    end

    // A stalled result holds its value.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_last))
        else $error("stalled output changed");

    // Every frame is exactly the full number of slots long.
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> (out_last == (slot_reg == SLOT_W'(TOTAL_SLOTS - 1))))
        else $error("last marker at the wrong slot");

    // Trailing slots carry a zero compare value.
    a_trail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && (slot_reg >= SLOT_W'(FRAME_BITS)) |-> (out_duty == '0))
        else $error("trailing slot not zero");

    // No output without an accepted item still owing slots.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("output without a pending item");

endmodule

bind dshot_throttle_frame_serializer dtfs_checker u_dtfs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_duty  (out_ch.duty),
    .out_last  (out_ch.last)
);
